/* rtl/lms_pkg.sv */
// shared types, constants and codes of the led matrix pattern sequencer
`default_nettype none

package lms_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int ROW_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int DUR_W   = 16;
    localparam int HOLD_W  = 17;
    localparam int RADDR_W = 4;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int INT_W   = 4;
    localparam int SCAN_W  = 3;

    // geometry and defaults
    localparam int ROWS              = 8;
    localparam int PATTERN_SLOTS_DEF = 16;
    localparam int MAX_ENTRIES_DEF   = 10;
    localparam int SETUP_WORDS       = 5;
    localparam int STEP_W            = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SETUP_WORDS + ROWS - 1);
    localparam int Q_DEPTH           = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SHOW    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN      = 2'd2;

    // driver chip register addresses
    localparam logic [RADDR_W-1:0] ADDR_DECODE    = 4'h9;
    localparam logic [RADDR_W-1:0] ADDR_INTENSITY = 4'hA;
    localparam logic [RADDR_W-1:0] ADDR_SCAN      = 4'hB;
    localparam logic [RADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [RADDR_W-1:0] ADDR_TEST      = 4'hF;
    localparam logic [RADDR_W-1:0] ADDR_LAST_ROW  = 4'h8;
    localparam logic [HOLD_W-1:0]  WORD_HOLD      = 17'd1;

    // set-up word positions
    localparam logic [STEP_W-1:0] STEP_DECODE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TEST      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WAKE      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_INTENSITY = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SCAN      = 4'd4;

    // show job handed from front to back
    typedef struct packed {
        logic              stop;
        logic [SLOT_W-1:0] slot;
        logic [DUR_W-1:0]  dur;
    } job_t;

    // pattern row write from front to back
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] data;
    } pat_wr_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // back status seen by front
    typedef struct packed {
        logic idle;
    } back_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/lms_queue.sv */
// two-entry job queue between front and back
`default_nettype none

module lms_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire lms_pkg::job_t     push_job,
    input  wire logic              pop,
    output lms_pkg::job_t          head_job,
    output lms_pkg::q_status_t     status
);

    localparam int PTR_W = (lms_pkg::Q_DEPTH > 1) ? $clog2(lms_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(lms_pkg::Q_DEPTH + 1);

    lms_pkg::job_t    q_mem_reg [lms_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lms_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lms_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = q_mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(lms_pkg::Q_DEPTH));

endmodule

`default_nettype wire

/* rtl/lms_front.sv */
// front end: accepts words, tracks the sequence and queues show jobs
`default_nettype none

module lms_front #(
    parameter int PATTERN_SLOTS = lms_pkg::PATTERN_SLOTS_DEF,
    parameter int MAX_ENTRIES   = lms_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lms_pkg::CMD_W-1:0]   s_cmd,
    input  wire logic [lms_pkg::SLOT_W-1:0]  s_pattern_index,
    input  wire logic [lms_pkg::ROW_W-1:0]   s_row_index,
    input  wire logic [lms_pkg::BYTE_W-1:0]  s_row_bits,
    input  wire logic [lms_pkg::DUR_W-1:0]   s_duration_ms,
    input  wire lms_pkg::q_status_t          q_status,
    input  wire lms_pkg::back_status_t       back_status,
    output logic                             q_push,
    output lms_pkg::job_t                    q_job,
    output lms_pkg::pat_wr_t                 pat_wr
);

    logic [lms_pkg::CNT_W-1:0] entries_reg, entries_next;
    logic                      stopped_reg, stopped_next;
    logic                      accept;
    logic                      show_live;
    logic                      end_show;
    logic                      slot_ok;

    // classify the word on the input
    assign show_live = (s_cmd == lms_pkg::CMD_SHOW) && !stopped_reg;
    assign end_show  = ((s_pattern_index == '0) && (s_duration_ms == '0)) ||
                       (entries_reg >= lms_pkg::CNT_W'(MAX_ENTRIES));
    assign slot_ok   = (32'(s_pattern_index) < PATTERN_SLOTS);

    // loads wait until the back has drained so earlier shows read old rows
    always_comb begin
        case (s_cmd)
            lms_pkg::CMD_LOAD: s_ready = back_status.idle && q_status.empty;
            lms_pkg::CMD_SHOW: s_ready = stopped_reg || !q_status.full;
            default:           s_ready = 1'b1;
        endcase
    end

    assign accept = s_valid && s_ready;

    // sequence state update and job push
    always_comb begin
        entries_next = entries_reg;
        stopped_next = stopped_reg;
        q_push       = 1'b0;
        q_job.stop   = end_show;
        q_job.slot   = s_pattern_index;
        q_job.dur    = s_duration_ms;
        if (accept) begin
            case (s_cmd)
                lms_pkg::CMD_RESTART: begin
                    entries_next = '0;
                    stopped_next = 1'b0;
                end
                lms_pkg::CMD_SHOW: begin
                    if (show_live) begin
                        q_push = 1'b1;
                        if (end_show) begin
                            stopped_next = 1'b1;
                        end else begin
                            entries_next = entries_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
            stopped_reg <= 1'b0;
        end else begin
            entries_reg <= entries_next;
            stopped_reg <= stopped_next;
        end
    end

    // row write toward the pattern store
    assign pat_wr.en   = accept && (s_cmd == lms_pkg::CMD_LOAD) && slot_ok;
    assign pat_wr.slot = s_pattern_index;
    assign pat_wr.row  = s_row_index;
    assign pat_wr.data = s_row_bits;

endmodule

`default_nettype wire

/* rtl/lms_back.sv */
// back end: pattern store, config registers and word sequencer
`default_nettype none

module lms_back #(
    parameter int PATTERN_SLOTS = lms_pkg::PATTERN_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lms_pkg::BYTE_W-1:0]    cfg_wdata,
    input  wire lms_pkg::pat_wr_t              pat_wr,
    input  wire lms_pkg::job_t                 head_job,
    input  wire lms_pkg::q_status_t            q_status,
    output logic                               q_pop,
    output lms_pkg::back_status_t              back_status,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lms_pkg::RADDR_W-1:0]        m_reg_addr,
    output logic [lms_pkg::BYTE_W-1:0]         m_reg_data,
    output logic [lms_pkg::HOLD_W-1:0]         m_hold_ms,
    output logic                               m_last,
    output logic                               m_ended
);

    localparam int MAX_SLOTS  = 1 << lms_pkg::SLOT_W;
    localparam int USED_SLOTS = (PATTERN_SLOTS < MAX_SLOTS) ? PATTERN_SLOTS : MAX_SLOTS;
    localparam int DEPTH      = USED_SLOTS * lms_pkg::ROWS;
    localparam int MA_W       = $clog2(DEPTH);

    // configuration registers
    logic [lms_pkg::BYTE_W-1:0] decode_reg;
    logic [lms_pkg::INT_W-1:0]  intensity_reg;
    logic [lms_pkg::SCAN_W-1:0] scan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_reg    <= '0;
            intensity_reg <= '1;
            scan_reg      <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lms_pkg::CFG_DECODE:    decode_reg    <= cfg_wdata;
                lms_pkg::CFG_INTENSITY: intensity_reg <= cfg_wdata[lms_pkg::INT_W-1:0];
                lms_pkg::CFG_SCAN:      scan_reg      <= cfg_wdata[lms_pkg::SCAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer registers
    lms_pkg::back_state_t       state_reg, state_next;
    logic [lms_pkg::STEP_W-1:0] step_reg, step_next;
    lms_pkg::job_t              job_reg, job_next;

    // pattern store with per-entry valid bits
    logic [lms_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           row_valid_reg;
    logic [lms_pkg::BYTE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic [lms_pkg::SLOT_W+lms_pkg::ROW_W-1:0] wr_full_addr, rd_full_addr;
    logic [MA_W-1:0]            wr_addr, rd_addr;
    logic [lms_pkg::STEP_W-1:0] rd_row_step;

    // read the row of the step that comes next, so data lines up with step_reg
    assign rd_row_step  = step_next - lms_pkg::STEP_W'(lms_pkg::SETUP_WORDS);
    assign wr_full_addr = {pat_wr.slot, pat_wr.row};
    assign rd_full_addr = {job_reg.slot, rd_row_step[lms_pkg::ROW_W-1:0]};
    assign wr_addr      = MA_W'(wr_full_addr);
    assign rd_addr      = MA_W'(rd_full_addr);

    always_ff @(posedge aclk) begin
        if (pat_wr.en) begin
            mem[wr_addr] <= pat_wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (pat_wr.en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // word of the current step
    logic                        slot_ok;
    logic                        is_row;
    logic [lms_pkg::STEP_W-1:0]  row_num;
    logic [lms_pkg::RADDR_W-1:0] w_addr;
    logic [lms_pkg::BYTE_W-1:0]  w_data;
    logic [lms_pkg::HOLD_W-1:0]  w_hold;
    logic                        w_last;
    logic                        w_ended;

    assign slot_ok = (32'(job_reg.slot) < PATTERN_SLOTS);
    assign is_row  = (step_reg >= lms_pkg::STEP_W'(lms_pkg::SETUP_WORDS));
    assign row_num = step_reg - lms_pkg::STEP_W'(lms_pkg::SETUP_WORDS - 1);

    always_comb begin
        w_addr  = lms_pkg::ADDR_DECODE;
        w_data  = decode_reg;
        w_hold  = lms_pkg::WORD_HOLD;
        w_last  = 1'b0;
        w_ended = 1'b0;
        if (job_reg.stop) begin
            w_addr  = lms_pkg::ADDR_SHUTDOWN;
            w_data  = '0;
            w_hold  = '0;
            w_last  = 1'b1;
            w_ended = 1'b1;
        end else if (is_row) begin
            w_addr = lms_pkg::RADDR_W'(row_num);
            w_data = (slot_ok && rd_valid_reg) ? rd_data_reg : '0;
            if (step_reg == lms_pkg::LAST_STEP) begin
                w_hold = lms_pkg::WORD_HOLD + lms_pkg::HOLD_W'(job_reg.dur);
                w_last = 1'b1;
            end
        end else begin
            case (step_reg)
                lms_pkg::STEP_DECODE: begin
                    w_addr = lms_pkg::ADDR_DECODE;
                    w_data = decode_reg;
                end
                lms_pkg::STEP_TEST: begin
                    w_addr = lms_pkg::ADDR_TEST;
                    w_data = '0;
                end
                lms_pkg::STEP_WAKE: begin
                    w_addr = lms_pkg::ADDR_SHUTDOWN;
                    w_data = lms_pkg::BYTE_W'(1);
                end
                lms_pkg::STEP_INTENSITY: begin
                    w_addr = lms_pkg::ADDR_INTENSITY;
                    w_data = lms_pkg::BYTE_W'(intensity_reg);
                end
                lms_pkg::STEP_SCAN: begin
                    w_addr = lms_pkg::ADDR_SCAN;
                    w_data = lms_pkg::BYTE_W'(scan_reg);
                end
                default: begin
                    w_addr = lms_pkg::ADDR_DECODE;
                    w_data = decode_reg;
                end
            endcase
        end
    end

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [lms_pkg::RADDR_W-1:0] m_addr_reg;
    logic [lms_pkg::BYTE_W-1:0]  m_data_reg;
    logic [lms_pkg::HOLD_W-1:0]  m_hold_reg;
    logic                        m_last_reg;
    logic                        m_ended_reg;
    logic                        out_free;
    logic                        load_word;

    assign out_free = !m_valid_reg || m_ready;

    // sequencer next state
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        job_next     = job_reg;
        q_pop        = 1'b0;
        load_word    = 1'b0;
        case (state_reg)
            lms_pkg::BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    job_next   = head_job;
                    step_next  = '0;
                    state_next = lms_pkg::BK_RUN;
                end
            end
            lms_pkg::BK_RUN: begin
                if (out_free) begin
                    load_word = 1'b1;
                    if (job_reg.stop || (step_reg == lms_pkg::LAST_STEP)) begin
                        state_next = lms_pkg::BK_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = lms_pkg::BK_IDLE;
            end
        endcase
        if (load_word) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lms_pkg::BK_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (load_word) begin
            m_addr_reg  <= w_addr;
            m_data_reg  <= w_data;
            m_hold_reg  <= w_hold;
            m_last_reg  <= w_last;
            m_ended_reg <= w_ended;
        end
    end

    assign back_status.idle = (state_reg == lms_pkg::BK_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_reg_addr = m_addr_reg;
    assign m_reg_data = m_data_reg;
    assign m_hold_ms  = m_hold_reg;
    assign m_last     = m_last_reg;
    assign m_ended    = m_ended_reg;

endmodule

`default_nettype wire

/* rtl/led_matrix_pattern_sequencer.sv */
// Top level of the led matrix pattern sequencer.
// Latency: a show's first word passes the job queue, the back job register and
// the output register before it is valid. Throughput: a show holds the back for
// a pop, then 13 words at one per cycle when unstalled; an end holds it for a pop
// and one shutdown word. Restarts never wait; a load waits for the queue and back to drain.
// Reset: synchronous; clears sequence state, queue, output valid and row valid bits, and sets settings to defaults.
`default_nettype none

module led_matrix_pattern_sequencer #(
    parameter int PATTERN_SLOTS = lms_pkg::PATTERN_SLOTS_DEF,
    parameter int MAX_ENTRIES   = lms_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lms_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [lms_pkg::SLOT_W-1:0]    s_pattern_index,
    input  wire logic [lms_pkg::ROW_W-1:0]     s_row_index,
    input  wire logic [lms_pkg::BYTE_W-1:0]    s_row_bits,
    input  wire logic [lms_pkg::DUR_W-1:0]     s_duration_ms,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lms_pkg::RADDR_W-1:0]        m_reg_addr,
    output logic [lms_pkg::BYTE_W-1:0]         m_reg_data,
    output logic [lms_pkg::HOLD_W-1:0]         m_hold_ms,
    output logic                               m_last,
    output logic                               m_ended,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lms_pkg::BYTE_W-1:0]    cfg_wdata
);

    lms_pkg::job_t         push_job;
    lms_pkg::job_t         head_job;
    lms_pkg::q_status_t    q_status;
    lms_pkg::back_status_t back_status;
    lms_pkg::pat_wr_t      pat_wr;
    logic                  q_push;
    logic                  q_pop;

    // front: accept and classify
    lms_front #(
        .PATTERN_SLOTS (PATTERN_SLOTS),
        .MAX_ENTRIES   (MAX_ENTRIES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_pattern_index (s_pattern_index),
        .s_row_index     (s_row_index),
        .s_row_bits      (s_row_bits),
        .s_duration_ms   (s_duration_ms),
        .q_status        (q_status),
        .back_status     (back_status),
        .q_push          (q_push),
        .q_job           (push_job),
        .pat_wr          (pat_wr)
    );

    // job queue
    lms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // back: word generation
    lms_back #(
        .PATTERN_SLOTS (PATTERN_SLOTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pat_wr      (pat_wr),
        .head_job    (head_job),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .back_status (back_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_reg_addr  (m_reg_addr),
        .m_reg_data  (m_reg_data),
        .m_hold_ms   (m_hold_ms),
        .m_last      (m_last),
        .m_ended     (m_ended)
    );

endmodule

`default_nettype wire

/* rtl/lms_checker.sv */
// port-level checker for the led matrix pattern sequencer and its bind
`default_nettype none

module lms_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [lms_pkg::RADDR_W-1:0] m_reg_addr,
    input wire logic [lms_pkg::BYTE_W-1:0]  m_reg_data,
    input wire logic [lms_pkg::HOLD_W-1:0]  m_hold_ms,
    input wire logic                       m_last,
    input wire logic                       m_ended
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reg_addr) && $stable(m_reg_data)
            && $stable(m_hold_ms) && $stable(m_last) && $stable(m_ended))
        else $error("stalled output word changed");

    // the closing word is a lone shutdown word
    a_end_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ended |-> m_last && (m_reg_addr == lms_pkg::ADDR_SHUTDOWN)
            && (m_reg_data == '0) && (m_hold_ms == '0))
        else $error("bad sequence end word");

    // a show finishes on the last row
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last && !m_ended |-> (m_reg_addr == lms_pkg::ADDR_LAST_ROW))
        else $error("show did not finish on last row");

    // every inner word holds for one millisecond
    a_inner_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> (m_hold_ms == lms_pkg::WORD_HOLD) && !m_ended)
        else $error("inner word with wrong hold");

endmodule

bind led_matrix_pattern_sequencer lms_checker u_lms_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_reg_addr (m_reg_addr),
    .m_reg_data (m_reg_data),
    .m_hold_ms  (m_hold_ms),
    .m_last     (m_last),
    .m_ended    (m_ended)
);

`default_nettype wire
